@@ rtl/core/stereo_widener_modulated_delay_core_assert.svh @@
// assertion macros for the stereo widener core
// no dependencies; included by files that carry concurrent checks
// bodies compile away when SYNTHESIS is defined
`ifndef STEREO_WIDENER_MODULATED_DELAY_CORE_ASSERT_SVH
`define STEREO_WIDENER_MODULATED_DELAY_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SWMD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SWMD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SWMD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define SWMD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/core/swmd_pkg.sv @@
// shared types, constants, microcode table and helper functions
// for the stereo widener core; no dependencies
package swmd_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int SUM_W      = 25;
  localparam int GAIN_W     = 18;
  localparam int BASE_W     = 12;
  localparam int DEPTH_W    = 12;
  localparam int PHASE_W    = 32;
  localparam int OUT_W      = 26;
  localparam int SINE_W     = 17;
  localparam int PROD_W     = SUM_W + GAIN_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [BASE_W-1:0]      DELAY_BASE_RESET = 12'd20;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 26'h1FF_FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 26'h200_0000;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_LEFT_DIRECT   = 3'd0,
    REG_GAIN_LEFT_DELAYED  = 3'd1,
    REG_GAIN_RIGHT_DIRECT  = 3'd2,
    REG_GAIN_RIGHT_DELAYED = 3'd3,
    REG_DELAY_BASE         = 3'd4,
    REG_MOD_DEPTH          = 3'd5,
    REG_PHASE_STEP         = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_left_direct;
    logic signed [GAIN_W-1:0] gain_left_delayed;
    logic signed [GAIN_W-1:0] gain_right_direct;
    logic signed [GAIN_W-1:0] gain_right_delayed;
    logic [BASE_W-1:0]        delay_base;
    logic [DEPTH_W-1:0]       mod_depth;
    logic [PHASE_W-1:0]       phase_step;
  } cfg_t;

  // program steps
  typedef enum logic [3:0] {
    P_CLEAR,
    P_IDLE,
    P_WRITE,
    P_SINE_RD,
    P_DEPTH_MUL,
    P_RD_ADDR,
    P_MEM_RD,
    P_MUL_LD,
    P_MUL_LX,
    P_MUL_RD,
    P_MUL_RX,
    P_SUB_R,
    P_OUT
  } step_t;

  typedef enum logic [1:0] {
    W_NONE,
    W_CLEAR,
    W_IN,
    W_OUT
  } wait_t;

  typedef enum logic [1:0] {
    A_SUM,
    A_DELAYED,
    A_DEPTH
  } opa_t;

  typedef enum logic [2:0] {
    B_GAIN_LD,
    B_GAIN_LX,
    B_GAIN_RD,
    B_GAIN_RX,
    B_SINE
  } opb_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    wait_t   wait_on;
    logic    jump;
    step_t   target;
    logic    mem_clr;
    logic    mem_wr;
    logic    load_sum;
    logic    idx_load;
    logic    base_load;
    logic    rd_load;
    logic    mul_en;
    opa_t    opa;
    opb_t    opb;
    acc_op_t acc_op;
    logic    left_load;
    logic    retire;
  } ctrl_t;

  typedef struct packed {
    ctrl_t word;
    logic  advance;
  } seq_out_t;

  typedef struct packed {
    logic clr_last;
    logic in_valid;
    logic out_full;
  } status_t;

  // control store: one word per step
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '0;
    unique case (s)
      P_CLEAR: begin
        w.wait_on = W_CLEAR;
        w.mem_clr = 1'b1;
      end
      P_IDLE: begin
        w.wait_on  = W_IN;
        w.load_sum = 1'b1;
      end
      P_WRITE: begin
        w.mem_wr    = 1'b1;
        w.idx_load  = 1'b1;
        w.base_load = 1'b1;
      end
      P_SINE_RD: begin
        w.mul_en = 1'b0;
      end
      P_DEPTH_MUL: begin
        w.mul_en = 1'b1;
        w.opa    = A_DEPTH;
        w.opb    = B_SINE;
      end
      P_RD_ADDR: begin
        w.rd_load = 1'b1;
      end
      P_MEM_RD: begin
        w.mul_en = 1'b0;
      end
      P_MUL_LD: begin
        w.mul_en = 1'b1;
        w.opa    = A_SUM;
        w.opb    = B_GAIN_LD;
      end
      P_MUL_LX: begin
        w.mul_en = 1'b1;
        w.opa    = A_DELAYED;
        w.opb    = B_GAIN_LX;
        w.acc_op = ACC_LOAD;
      end
      P_MUL_RD: begin
        w.mul_en = 1'b1;
        w.opa    = A_SUM;
        w.opb    = B_GAIN_RD;
        w.acc_op = ACC_SUB;
      end
      P_MUL_RX: begin
        w.mul_en    = 1'b1;
        w.opa       = A_DELAYED;
        w.opb       = B_GAIN_RX;
        w.acc_op    = ACC_LOAD;
        w.left_load = 1'b1;
      end
      P_SUB_R: begin
        w.acc_op = ACC_SUB;
      end
      P_OUT: begin
        w.wait_on = W_OUT;
        w.retire  = 1'b1;
        w.jump    = 1'b1;
        w.target  = P_IDLE;
      end
      default: begin
        w.jump   = 1'b1;
        w.target = P_IDLE;
      end
    endcase
    return w;
  endfunction

  // quarter-wave sine entry in q1.16 from a q30 angle fraction
  function automatic logic [SINE_W-1:0] sine_entry(input longint unsigned u);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned r;
    longint unsigned s;
    x  = (u * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    r  = Q30_ONE - x2 / 110;
    r  = Q30_ONE - ((x2 * r) >> 30) / 72;
    r  = Q30_ONE - ((x2 * r) >> 30) / 42;
    r  = Q30_ONE - ((x2 * r) >> 30) / 20;
    r  = Q30_ONE - ((x2 * r) >> 30) / 6;
    s  = (x * r) >> 30;
    return SINE_W'((s + 64'd8192) >> 14);
  endfunction

  // floor shift by the fraction width, then clamp to the output range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-OUT_W-FRAC_W:0] top;
    top = v[ACC_W-1:OUT_W+FRAC_W-1];
    if (top == '0 || top == '1) begin
      return v[OUT_W+FRAC_W-1:FRAC_W];
    end
    return v[ACC_W-1] ? OUT_MIN : OUT_MAX;
  endfunction

endpackage

@@ rtl/core/swmd_if.sv @@
// stream interfaces for stereo sample pairs in and widened pairs out
// depends on swmd_pkg
interface swmd_in_if;
  import swmd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_in;
  logic signed [SAMPLE_W-1:0] right_in;
  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface swmd_out_if;
  import swmd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] left_out;
  logic signed [OUT_W-1:0] right_out;
  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

@@ rtl/core/swmd_delay_ram.sv @@
// ring delay store: one write port, one registered read port
// depends on swmd_pkg
module swmd_delay_ram #(
  parameter int RING_LEN = 4410,
  localparam int ADDR_W = $clog2(RING_LEN)
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [ADDR_W-1:0]                 waddr,
  input  logic signed [swmd_pkg::SUM_W-1:0] wdata,
  input  logic [ADDR_W-1:0]                 raddr,
  output logic signed [swmd_pkg::SUM_W-1:0] rdata
);
  import swmd_pkg::*;

  logic signed [SUM_W-1:0] mem [RING_LEN];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/swmd_sine_rom.sv @@
// |sin| lookup: phase to table index, quarter-wave rom, registered read
// depends on swmd_pkg (table contents come from sine_entry)
module swmd_sine_rom #(
  parameter int SINE_TABLE_DEPTH = 1024,
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic                          clk,
  input  logic [swmd_pkg::PHASE_W-1:0]  phase,
  input  logic                          idx_load,
  output logic [swmd_pkg::SINE_W-1:0]   sine
);
  import swmd_pkg::*;

  localparam int D_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SC_W = 30 + D_W;

  logic [SINE_W-1:0] rom [SINE_TABLE_DEPTH];
  logic [SC_W-1:0]   scaled;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  mirror;
  logic [IDX_W-1:0]  idx;

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam longint unsigned U = (64'(g) << 30) / SINE_TABLE_DEPTH;
    assign rom[g] = sine_entry(U);
  end

  // index within the quadrant, mirrored in odd quadrants
  always_comb begin
    scaled = SC_W'(phase[29:0]) * SC_W'(SINE_TABLE_DEPTH);
    j      = scaled[30 +: IDX_W];
    mirror = IDX_W'(SINE_TABLE_DEPTH - 1) - j;
  end

  always_ff @(posedge clk) begin
    if (idx_load) begin
      idx <= phase[30] ? mirror : j;
    end
  end

  always_ff @(posedge clk) begin
    sine <= rom[idx];
  end

endmodule

@@ rtl/core/swmd_datapath.sv @@
// datapath: shared multiplier, accumulator, ring addressing, lfo phase
// depends on swmd_pkg; driven by the control word of swmd_sequencer
module swmd_datapath #(
  parameter int RING_LEN = 4410,
  localparam int ADDR_W = $clog2(RING_LEN)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  swmd_pkg::seq_out_t                   seq,
  input  swmd_pkg::cfg_t                       cfg,
  input  logic signed [swmd_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [swmd_pkg::SAMPLE_W-1:0] right_in,
  input  logic [swmd_pkg::SINE_W-1:0]          sine,
  input  logic signed [swmd_pkg::SUM_W-1:0]    ram_rdata,
  output logic                                 ram_we,
  output logic [ADDR_W-1:0]                    ram_waddr,
  output logic signed [swmd_pkg::SUM_W-1:0]    ram_wdata,
  output logic [ADDR_W-1:0]                    ram_raddr,
  output logic [swmd_pkg::PHASE_W-1:0]         phase,
  output logic                                 clr_last,
  output logic signed [swmd_pkg::OUT_W-1:0]    left_res,
  output logic signed [swmd_pkg::OUT_W-1:0]    right_res
);
  import swmd_pkg::*;

  localparam logic [ADDR_W:0]   RING      = (ADDR_W + 1)'(RING_LEN);
  localparam logic [ADDR_W-1:0] RING_LAST = ADDR_W'(RING_LEN - 1);

  ctrl_t w;
  logic  adv;

  logic signed [SUM_W-1:0]  sum;
  logic [ADDR_W-1:0]        write_pos;
  logic [ADDR_W-1:0]        clr_cnt;
  logic [ADDR_W-1:0]        base_addr;
  logic [ADDR_W-1:0]        rd_addr;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [OUT_W-1:0]  left_hold;
  logic [PHASE_W-1:0]       lfo_phase;

  logic signed [SUM_W-1:0]  mul_a;
  logic signed [GAIN_W-1:0] mul_b;
  logic [ADDR_W:0]          base_sum;
  logic [ADDR_W:0]          base_wrap;
  logic [ADDR_W:0]          rd_sum;
  logic [ADDR_W:0]          rd_wrap;

  assign w   = seq.word;
  assign adv = seq.advance;

  // operand select for the shared multiplier
  always_comb begin
    unique case (w.opa)
      A_SUM:     mul_a = sum;
      A_DELAYED: mul_a = ram_rdata;
      A_DEPTH:   mul_a = $signed({{(SUM_W - DEPTH_W){1'b0}}, cfg.mod_depth});
      default:   mul_a = sum;
    endcase
    unique case (w.opb)
      B_GAIN_LD: mul_b = cfg.gain_left_direct;
      B_GAIN_LX: mul_b = cfg.gain_left_delayed;
      B_GAIN_RD: mul_b = cfg.gain_right_direct;
      B_GAIN_RX: mul_b = cfg.gain_right_delayed;
      B_SINE:    mul_b = $signed({{(GAIN_W - SINE_W){1'b0}}, sine});
      default:   mul_b = cfg.gain_left_direct;
    endcase
  end

  // ring offsets stay below twice the ring length, one subtract wraps
  always_comb begin
    base_sum  = {1'b0, write_pos} + (ADDR_W + 1)'(cfg.delay_base);
    base_wrap = (base_sum >= RING) ? base_sum - RING : base_sum;
    rd_sum    = {1'b0, base_addr} + (ADDR_W + 1)'(prod[FRAC_W +: DEPTH_W]);
    rd_wrap   = (rd_sum >= RING) ? rd_sum - RING : rd_sum;
  end

  always_ff @(posedge clk) begin
    if (w.load_sum && adv) begin
      sum <= SUM_W'(left_in) + SUM_W'(right_in);
    end
    if (w.base_load && adv) begin
      base_addr <= base_wrap[ADDR_W-1:0];
    end
    if (w.rd_load && adv) begin
      rd_addr <= rd_wrap[ADDR_W-1:0];
    end
    if (w.mul_en && adv) begin
      prod <= mul_a * mul_b;
    end
    if (adv) begin
      unique case (w.acc_op)
        ACC_LOAD: acc <= ACC_W'(prod);
        ACC_SUB:  acc <= acc - ACC_W'(prod);
        default:  acc <= acc;
      endcase
    end
    if (w.left_load && adv) begin
      left_hold <= sat_out(acc);
    end
  end

  // position, clear sweep and phase are reset state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
      clr_cnt   <= '0;
      lfo_phase <= '0;
    end else begin
      if (w.mem_clr && !clr_last) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (w.retire && adv) begin
        write_pos <= (write_pos == '0) ? RING_LAST : write_pos - 1'b1;
        if (cfg.mod_depth != '0) begin
          lfo_phase <= lfo_phase + cfg.phase_step;
        end
      end
    end
  end

  assign clr_last  = (clr_cnt == RING_LAST);
  assign ram_we    = w.mem_clr || (w.mem_wr && adv);
  assign ram_waddr = w.mem_clr ? clr_cnt : write_pos;
  assign ram_wdata = w.mem_clr ? '0 : sum;
  assign ram_raddr = rd_addr;
  assign phase     = lfo_phase;
  assign left_res  = left_hold;
  assign right_res = sat_out(acc);

endmodule

@@ rtl/core/swmd_sequencer.sv @@
// microcode sequencer: step counter, control store lookup, wait and jump
// depends on swmd_pkg and the assertion macro header
`include "stereo_widener_modulated_delay_core_assert.svh"

module swmd_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  swmd_pkg::status_t  status,
  output swmd_pkg::seq_out_t seq,
  output logic               in_ready
);
  import swmd_pkg::*;

  step_t pc;
  step_t pc_next;
  ctrl_t word;
  logic  stall;
  logic  in_fire;

  assign word = ucode(pc);

  always_comb begin
    unique case (word.wait_on)
      W_NONE:  stall = 1'b0;
      W_CLEAR: stall = !status.clr_last;
      W_IN:    stall = !status.in_valid;
      W_OUT:   stall = status.out_full;
      default: stall = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    priority if (stall) begin
      pc_next = pc;
    end else if (word.jump) begin
      pc_next = word.target;
    end else begin
      pc_next = step_t'(pc + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= P_CLEAR;
    end else begin
      pc <= pc_next;
    end
  end

  // outputs
  always_comb begin
    seq.word    = word;
    seq.advance = !stall;
    in_ready    = (word.wait_on == W_IN);
  end

  assign in_fire = status.in_valid && in_ready;

  `SWMD_ASSERT_NEXT(a_accept_starts, clk, rst, in_fire, pc == P_WRITE, "transfer did not start program")
  `SWMD_ASSERT_NEXT(a_out_hold, clk, rst, (pc == P_OUT) && status.out_full, pc == P_OUT, "left result step while output full")
  `SWMD_ASSERT_NEXT(a_out_return, clk, rst, (pc == P_OUT) && !status.out_full, pc == P_IDLE, "no return to idle after result")
  `SWMD_ASSERT_NEXT(a_clear_done, clk, rst, (pc == P_CLEAR) && status.clr_last, pc == P_IDLE, "clear sweep did not finish")

endmodule

@@ rtl/core/stereo_widener_modulated_delay_core.sv @@
// top level of the stereo widener with modulated delay
// depends on swmd_pkg, swmd_if, swmd_sequencer, swmd_datapath,
// swmd_delay_ram and swmd_sine_rom
//
// each transferred stereo pair is summed to mono, written into a ring delay
// store, and read back at delay_base plus floor(mod_depth * |sin(phase)|)
// samples; each output channel is direct gain times the sum minus delayed
// gain times the delayed sample, floor-shifted by 16 and clamped to 26 bits.
// after reset the block sweeps the ring to zero, one entry a cycle, and
// takes no pair until that ends (register writes are taken all the time).
// then each pair runs the whole microprogram, which runs all five products
// through one shared multiplier and waits on the registered reads of the
// sine table and the ring store; the next pair is taken only once the
// program is back at its idle step. a finished result waits in the output
// register while the next pair is already being worked on. configuration is
// written through cfg_wen / cfg_index / cfg_data; the user must write it only
// while no pair is in flight, the block itself does not enforce this.
module stereo_widener_modulated_delay_core #(
  parameter int RING_LEN = 4410,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  swmd_in_if.sink                              stereo,
  swmd_out_if.source                           widened,
  input  logic                                 cfg_wen,
  input  logic [swmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [swmd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import swmd_pkg::*;

  localparam int ADDR_W = $clog2(RING_LEN);

  cfg_t     cfg;
  status_t  status;
  seq_out_t seq;
  logic     in_ready;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [ADDR_W-1:0]       ram_raddr;
  logic signed [SUM_W-1:0] ram_wdata;
  logic signed [SUM_W-1:0] ram_rdata;
  logic [PHASE_W-1:0]      phase;
  logic [SINE_W-1:0]       sine;
  logic                    clr_last;
  logic signed [OUT_W-1:0] left_res;
  logic signed [OUT_W-1:0] right_res;

  logic                    out_valid;
  logic signed [OUT_W-1:0] out_left;
  logic signed [OUT_W-1:0] out_right;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_left_direct   <= '0;
      cfg.gain_left_delayed  <= '0;
      cfg.gain_right_direct  <= '0;
      cfg.gain_right_delayed <= '0;
      cfg.delay_base         <= DELAY_BASE_RESET;
      cfg.mod_depth          <= '0;
      cfg.phase_step         <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_GAIN_LEFT_DIRECT:   cfg.gain_left_direct   <= cfg_data[GAIN_W-1:0];
        REG_GAIN_LEFT_DELAYED:  cfg.gain_left_delayed  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_RIGHT_DIRECT:  cfg.gain_right_direct  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_RIGHT_DELAYED: cfg.gain_right_delayed <= cfg_data[GAIN_W-1:0];
        REG_DELAY_BASE:         cfg.delay_base         <= cfg_data[BASE_W-1:0];
        REG_MOD_DEPTH:          cfg.mod_depth          <= cfg_data[DEPTH_W-1:0];
        REG_PHASE_STEP:         cfg.phase_step         <= cfg_data[PHASE_W-1:0];
        default:                cfg                    <= cfg;
      endcase
    end
  end

  // output is busy unless it drains in this cycle
  assign status.clr_last = clr_last;
  assign status.in_valid = stereo.valid;
  assign status.out_full = out_valid && !widened.ready;

  assign stereo.ready = in_ready;

  swmd_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .seq      (seq),
    .in_ready (in_ready)
  );

  swmd_datapath #(
    .RING_LEN (RING_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .seq       (seq),
    .cfg       (cfg),
    .left_in   (stereo.left_in),
    .right_in  (stereo.right_in),
    .sine      (sine),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .phase     (phase),
    .clr_last  (clr_last),
    .left_res  (left_res),
    .right_res (right_res)
  );

  swmd_delay_ram #(
    .RING_LEN (RING_LEN)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  swmd_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine (
    .clk      (clk),
    .phase    (phase),
    .idx_load (seq.word.idx_load),
    .sine     (sine)
  );

  // output register, loaded at the last program step
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq.word.retire && seq.advance) begin
      out_valid <= 1'b1;
    end else if (widened.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq.word.retire && seq.advance) begin
      out_left  <= left_res;
      out_right <= right_res;
    end
  end

  assign widened.valid     = out_valid;
  assign widened.left_out  = out_left;
  assign widened.right_out = out_right;

endmodule

@@ test/tb.sv @@
// testbench for stereo_widener_modulated_delay_core: streams stereo pairs in and
// checks each widened pair against a bit-accurate predictor of the block
// depends on swmd_pkg, swmd_if and the core rtl
module tb;
  import swmd_pkg::*;

  localparam int RING_LEN      = 4410;
  localparam int SINE_DEPTH    = 1024;
  localparam int WAIT_MAX      = 17;     // longest gap or stall drawn per transfer
  localparam int QUIET_LIMIT   = 30000;  // covers the ring clear after reset many times over
  localparam int SETTLE_CYCLES = 40;     // a few pair latencies after the last result
  localparam int RANDOM_PAIRS  = 950;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI = 24'sh7F_FFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = 24'sh80_0000;
  localparam longint OUT_HI    = 33554431;
  localparam longint OUT_LO    = -33554432;

  // no register lives at this index; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] right;
  } widened_pair_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  swmd_in_if  stereo();
  swmd_out_if widened();

  stereo_widener_modulated_delay_core #(
    .RING_LEN(RING_LEN),
    .SINE_TABLE_DEPTH(SINE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .stereo(stereo),
    .widened(widened),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state: its own copy of the ring, pointers and registers
  int                      quarter_sine [SINE_DEPTH];
  logic signed [SUM_W-1:0] mono_ring [RING_LEN];
  int                      wr_pos;
  logic [PHASE_W-1:0]      lfo;
  cfg_t                    cfg;

  widened_pair_t widened_due [$];  // expected pairs, oldest first
  int            errors;
  int            quiet;            // cycles since the last transfer on either side
  bit            idle_on;          // when clear both sides run flat out

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // quarter-wave |sin| in q1.16, built in q30 fixed point with a taylor series
  function automatic void build_quarter_sine();
    longint unsigned u, x, x2, r, s;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      u = i;
      u = (u << 30) / SINE_DEPTH;
      x = (u * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      r = Q30_ONE - x2 / 110;
      r = Q30_ONE - ((x2 * r) >> 30) / 72;
      r = Q30_ONE - ((x2 * r) >> 30) / 42;
      r = Q30_ONE - ((x2 * r) >> 30) / 20;
      r = Q30_ONE - ((x2 * r) >> 30) / 6;
      s = (x * r) >> 30;
      quarter_sine[i] = int'((s + 8192) >> 14);
    end
  endfunction

  // top two phase bits pick the quadrant; odd quadrants run the table backwards
  function automatic int abs_sine_at(input logic [PHASE_W-1:0] ph);
    longint j;
    j = (longint'(ph[29:0]) * SINE_DEPTH) >>> 30;
    if (ph[30]) j = SINE_DEPTH - 1 - j;
    return quarter_sine[j];
  endfunction

  // floor shift out the q16 fraction, then clamp to 26 bits
  function automatic logic signed [OUT_W-1:0] scale_clamp(input longint acc);
    longint q;
    q = acc >>> FRAC_W;
    if (q > OUT_HI) q = OUT_HI;
    else if (q < OUT_LO) q = OUT_LO;
    return q[OUT_W-1:0];
  endfunction

  // one accepted pair: write the mono sum, read the tap, mix, advance
  function automatic widened_pair_t widen_pair(input logic signed [SAMPLE_W-1:0] l,
                                               input logic signed [SAMPLE_W-1:0] r);
    longint        sum, dl, lo, ro;
    int            extra, rd;
    widened_pair_t res;
    sum = longint'(l) + longint'(r);
    // write before read, so a tap distance of a whole ring returns this sum
    mono_ring[wr_pos] = sum[SUM_W-1:0];
    extra = 0;
    if (cfg.mod_depth != 0)
      extra = int'((longint'(cfg.mod_depth) * longint'(abs_sine_at(lfo))) >>> 16);
    rd = (wr_pos + int'(cfg.delay_base) + extra) % RING_LEN;
    dl = longint'(mono_ring[rd]);
    lo = sum * longint'(cfg.gain_left_direct) - dl * longint'(cfg.gain_left_delayed);
    ro = sum * longint'(cfg.gain_right_direct) - dl * longint'(cfg.gain_right_delayed);
    res.left = scale_clamp(lo);
    res.right = scale_clamp(ro);
    wr_pos = (wr_pos == 0) ? RING_LEN - 1 : wr_pos - 1;
    // the lfo only runs while modulation is on
    if (cfg.mod_depth != 0) lfo = lfo + cfg.phase_step;
    return res;
  endfunction

  function automatic int draw_wait();
    return idle_on ? int'($urandom_range(0, WAIT_MAX)) : 0;
  endfunction

  // random bits above the register width; the block must drop them
  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
                                                      input int w);
    logic [CFG_DATA_W-1:0] keep;
    if (w >= CFG_DATA_W) return v;
    keep = (32'h1 << w) - 32'h1;
    return ($urandom() & ~keep) | (v & keep);
  endfunction

  function automatic cfg_t make_settings(input int gld, input int glx, input int grd,
                                         input int grx, input int base, input int depth,
                                         input logic [PHASE_W-1:0] step);
    cfg_t s;
    s.gain_left_direct   = gld[GAIN_W-1:0];
    s.gain_left_delayed  = glx[GAIN_W-1:0];
    s.gain_right_direct  = grd[GAIN_W-1:0];
    s.gain_right_delayed = grx[GAIN_W-1:0];
    s.delay_base         = base[BASE_W-1:0];
    s.mod_depth          = depth[DEPTH_W-1:0];
    s.phase_step         = step;
    return s;
  endfunction

  // one register write; leaves cfg_wen high so writes can run back to back
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_GAIN_LEFT_DIRECT:   cfg.gain_left_direct   = value[GAIN_W-1:0];
      REG_GAIN_LEFT_DELAYED:  cfg.gain_left_delayed  = value[GAIN_W-1:0];
      REG_GAIN_RIGHT_DIRECT:  cfg.gain_right_direct  = value[GAIN_W-1:0];
      REG_GAIN_RIGHT_DELAYED: cfg.gain_right_delayed = value[GAIN_W-1:0];
      REG_DELAY_BASE:         cfg.delay_base         = value[BASE_W-1:0];
      REG_MOD_DEPTH:          cfg.mod_depth          = value[DEPTH_W-1:0];
      REG_PHASE_STEP:         cfg.phase_step         = value[PHASE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t s);
    put_reg(REG_GAIN_LEFT_DIRECT, with_junk(32'(s.gain_left_direct), GAIN_W));
    put_reg(REG_GAIN_LEFT_DELAYED, with_junk(32'(s.gain_left_delayed), GAIN_W));
    put_reg(REG_GAIN_RIGHT_DIRECT, with_junk(32'(s.gain_right_direct), GAIN_W));
    put_reg(REG_GAIN_RIGHT_DELAYED, with_junk(32'(s.gain_right_delayed), GAIN_W));
    put_reg(REG_DELAY_BASE, with_junk(32'(s.delay_base), BASE_W));
    put_reg(REG_MOD_DEPTH, with_junk(32'(s.mod_depth), DEPTH_W));
    put_reg(REG_PHASE_STEP, s.phase_step);
    cfg_wen <= 1'b0;
  endtask

  // valid stays high into the next pair when no gap is drawn
  task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                           input logic signed [SAMPLE_W-1:0] r);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      stereo.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stereo.valid    <= 1'b1;
    stereo.left_in  <= l;
    stereo.right_in <= r;
    do @(posedge clk); while (stereo.ready !== 1'b1);
    widened_due.push_back(widen_pair(l, r));
  endtask

  // stop the stream and let every expected pair come out
  task automatic wait_drained();
    stereo.valid <= 1'b0;
    while (widened_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? SAMPLE_HI : SAMPLE_LO;
      1: return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic int pick_gain();
    case ($urandom_range(0, 15))
      0, 1: return 65536;
      2, 3: return -65536;
      4: return int'($urandom_range(0, 262143)) - 131072;  // any 18-bit pattern
      default: return int'($urandom_range(0, 131072)) - 65536;
    endcase
  endfunction

  function automatic int pick_base();
    case ($urandom_range(0, 15))
      0, 1: return 20;
      2, 3: return 2100;
      4: return 0;
      5: return 4095;
      default: return int'($urandom_range(20, 2100));
    endcase
  endfunction

  function automatic int pick_depth();
    case ($urandom_range(0, 15))
      0, 1, 2, 3: return 0;
      4, 5: return 2100;
      6: return 4095;
      default: return int'($urandom_range(1, 2100));
    endcase
  endfunction

  function automatic logic [PHASE_W-1:0] pick_step();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // reset values: all gains zero, so every output is zero
  task automatic test_reset_state();
    send_pair(SAMPLE_HI, SAMPLE_HI);
    send_pair(SAMPLE_LO, 24'sd1);
    wait_drained();
  endtask

  // unity gains of both signs against the extremes of both samples
  task automatic test_gain_extremes();
    apply_settings(make_settings(65536, -65536, -65536, 65536, 20, 0, '0));
    send_pair(SAMPLE_HI, SAMPLE_HI);
    send_pair(SAMPLE_LO, SAMPLE_LO);
    send_pair(SAMPLE_HI, SAMPLE_LO);
    send_pair(24'sd0, 24'sd0);
    send_pair(24'sd1, -24'sd2);
    wait_drained();
  endtask

  // full-scale gain patterns with a zero tap distance drive both clamps
  task automatic test_saturation();
    apply_settings(make_settings(-131072, 131071, 131071, -131072, 0, 0, '0));
    send_pair(SAMPLE_LO, SAMPLE_LO);
    send_pair(SAMPLE_HI, SAMPLE_HI);
    send_pair(SAMPLE_LO, SAMPLE_HI);
    send_pair(24'sd3, -24'sd7);
    wait_drained();
  endtask

  // quarter-turn steps alternate |sin| between 0 and its peak; the base is
  // picked so the peak lands the tap exactly one ring away, then a long base
  // with deep modulation wraps past the ring end; four quarter turns wrap the phase
  task automatic test_modulated_delay();
    int extra_hi;
    extra_hi = (4095 * quarter_sine[SINE_DEPTH-1]) >>> 16;
    apply_settings(make_settings(65536, 32768, -65536, -32768, RING_LEN - extra_hi, 4095,
                                 32'h4000_0000));
    for (int k = 0; k < 4; k++) send_pair(pick_sample(), pick_sample());
    wait_drained();
    apply_settings(make_settings(49152, -65536, 16384, 65536, 4095, 2100, 32'h2000_0000));
    for (int k = 0; k < 4; k++) send_pair(pick_sample(), pick_sample());
    wait_drained();
  endtask

  // a write to the empty index must leave all registers alone
  task automatic test_unknown_index();
    put_reg(REG_UNUSED, '1);
    put_reg(REG_UNUSED, $urandom());
    cfg_wen <= 1'b0;
    send_pair(pick_sample(), pick_sample());
    send_pair(pick_sample(), pick_sample());
    wait_drained();
  endtask

  // random settings per phase, random pairs, idling on in most phases
  task automatic test_random_phases();
    int sent, len;
    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      len = $urandom_range(20, 120);
      if (len > RANDOM_PAIRS - sent) len = RANDOM_PAIRS - sent;
      idle_on = ($urandom_range(0, 3) != 0);
      apply_settings(make_settings(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                                   pick_base(), pick_depth(), pick_step()));
      for (int k = 0; k < len; k++) send_pair(pick_sample(), pick_sample());
      sent += len;
      wait_drained();
    end
    idle_on = 1'b1;
  endtask

  // output side: a fresh stall draw after every transfer
  initial begin
    int stall;
    widened.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        widened.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      widened.ready <= 1'b1;
      do @(posedge clk); while (widened.valid !== 1'b1);
    end
  end

  // result check and watchdog, sampled on the pre-edge values
  always @(posedge clk) begin
    widened_pair_t due;
    if (!rst) begin
      if ((stereo.valid && stereo.ready) || (widened.valid && widened.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: errors");
        $finish;
      end else if (widened.valid && widened.ready) begin
        if (widened_due.size() == 0) begin
          $error("result with nothing expected: left_out %0d right_out %0d",
                 widened.left_out, widened.right_out);
          errors++;
        end else begin
          due = widened_due.pop_front();
          if (widened.left_out !== due.left) begin
            $error("left_out: expected %0d, got %0d", due.left, widened.left_out);
            errors++;
          end
          if (widened.right_out !== due.right) begin
            $error("right_out: expected %0d, got %0d", due.right, widened.right_out);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    errors  = 0;
    quiet   = 0;
    idle_on = 1'b1;
    build_quarter_sine();
    foreach (mono_ring[k]) mono_ring[k] = '0;
    wr_pos = 0;
    lfo    = '0;
    cfg    = make_settings(0, 0, 0, 0, int'(DELAY_BASE_RESET), 0, '0);

    rst             <= 1'b1;
    cfg_wen         <= 1'b0;
    cfg_index       <= REG_GAIN_LEFT_DIRECT;
    cfg_data        <= '0;
    stereo.valid    <= 1'b0;
    stereo.left_in  <= '0;
    stereo.right_in <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // the block clears its ring first; the first transfer waits on that
    test_reset_state();
    test_gain_extremes();
    test_saturation();
    test_modulated_delay();
    test_unknown_index();
    test_random_phases();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/swmd_pkg.sv
rtl/core/swmd_if.sv
rtl/core/swmd_delay_ram.sv
rtl/core/swmd_sine_rom.sv
rtl/core/swmd_datapath.sv
rtl/core/swmd_sequencer.sv
rtl/core/stereo_widener_modulated_delay_core.sv
test/tb.sv
